>>> rtl/fca_pkg.sv
// Shared types, constants and the microcode table of the FAT chain allocator.
package fca_pkg;

   localparam int NUM_BLOCKS = 1024;
   localparam int ADDR_W     = $clog2(NUM_BLOCKS);
   localparam int PC_W       = 5;

   localparam logic [15:0] FREE_MARK = 16'h0000;
   localparam logic [15:0] END_MARK  = 16'hFFFF;
   localparam logic [15:0] BLK_LIMIT = 16'(NUM_BLOCKS);
   localparam logic [15:0] BLK_LAST  = 16'(NUM_BLOCKS - 1);

   localparam logic [1:0] OP_ALLOC = 2'd0;
   localparam logic [1:0] OP_FREE  = 2'd1;
   localparam logic [1:0] OP_READ  = 2'd2;
   localparam logic [1:0] OP_CLEAR = 2'd3;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_FULL  = 2'd1;
   localparam logic [1:0] ST_LOOP  = 2'd2;
   localparam logic [1:0] ST_RANGE = 2'd3;

   typedef struct packed {
      logic [1:0]  operation;
      logic [15:0] block;
   } req_type;

   typedef struct packed {
      logic [15:0] result_block;
      logic [15:0] freed_count;
      logic [1:0]  status;
   } rsp_type;

   typedef enum logic [3:0] {
      COND_NEXT,
      COND_ALWAYS,
      COND_BLK_OOR,
      COND_RD_ZERO,
      COND_NOT_LAST,
      COND_PTR_END,
      COND_PTR_OOR,
      COND_CNT_FULL,
      COND_BLK_ZERO
   } cond_type;

   typedef enum logic [2:0] {
      PTR_HOLD,
      PTR_ONE,
      PTR_ZERO,
      PTR_INC,
      PTR_LOAD_RD
   } ptr_op_type;

   typedef enum logic [1:0] {
      CNT_HOLD,
      CNT_INC
   } cnt_op_type;

   typedef enum logic [1:0] {
      WR_NONE,
      WR_PTR_FREE,
      WR_PTR_END,
      WR_BLK_LINK
   } wr_op_type;

   typedef enum logic [1:0] {
      RES_ZERO,
      RES_PTR,
      RES_RD
   } res_sel_type;

   typedef struct packed {
      cond_type         cond;
      logic [PC_W-1:0]  target;
      ptr_op_type       ptr_op;
      cnt_op_type       cnt_op;
      wr_op_type        wr_op;
      logic             emit;
      res_sel_type      res_sel;
      logic [1:0]       status;
   } ctrl_word_type;

   typedef struct packed {
      logic blk_oor;
      logic blk_zero;
      logic rd_zero;
      logic ptr_last;
      logic ptr_end;
      logic ptr_oor;
      logic cnt_full;
   } flags_type;

   // program addresses
   localparam logic [PC_W-1:0] PC_IDLE    = 5'd0;
   localparam logic [PC_W-1:0] PC_ALLOC   = 5'd1;
   localparam logic [PC_W-1:0] PC_A_TEST  = 5'd2;
   localparam logic [PC_W-1:0] PC_A_STEP  = 5'd3;
   localparam logic [PC_W-1:0] PC_A_FULL  = 5'd4;
   localparam logic [PC_W-1:0] PC_A_HIT   = 5'd5;
   localparam logic [PC_W-1:0] PC_A_LINK  = 5'd6;
   localparam logic [PC_W-1:0] PC_A_OK    = 5'd7;
   localparam logic [PC_W-1:0] PC_A_RANGE = 5'd8;
   localparam logic [PC_W-1:0] PC_FREE    = 5'd9;
   localparam logic [PC_W-1:0] PC_F_OOR   = 5'd10;
   localparam logic [PC_W-1:0] PC_F_CNT   = 5'd11;
   localparam logic [PC_W-1:0] PC_F_STEP  = 5'd12;
   localparam logic [PC_W-1:0] PC_F_OK    = 5'd13;
   localparam logic [PC_W-1:0] PC_F_RANGE = 5'd14;
   localparam logic [PC_W-1:0] PC_F_LONG  = 5'd15;
   localparam logic [PC_W-1:0] PC_READ    = 5'd16;
   localparam logic [PC_W-1:0] PC_R_OK    = 5'd17;
   localparam logic [PC_W-1:0] PC_R_RANGE = 5'd18;
   localparam logic [PC_W-1:0] PC_CLEAR   = 5'd19;
   localparam logic [PC_W-1:0] PC_C_LOOP  = 5'd20;
   localparam logic [PC_W-1:0] PC_C_DONE  = 5'd21;

   function automatic ctrl_word_type mk(input cond_type cond, input logic [PC_W-1:0] target,
                                        input ptr_op_type ptr_op, input cnt_op_type cnt_op,
                                        input wr_op_type wr_op, input logic emit,
                                        input res_sel_type res_sel, input logic [1:0] status);
      ctrl_word_type w;
      w.cond    = cond;
      w.target  = target;
      w.ptr_op  = ptr_op;
      w.cnt_op  = cnt_op;
      w.wr_op   = wr_op;
      w.emit    = emit;
      w.res_sel = res_sel;
      w.status  = status;
      return w;
   endfunction

   function automatic logic [PC_W-1:0] entry_pc(input logic [1:0] op);
      logic [PC_W-1:0] pc;
      case (op)
         OP_ALLOC: pc = PC_ALLOC;
         OP_FREE:  pc = PC_FREE;
         OP_READ:  pc = PC_READ;
         OP_CLEAR: pc = PC_CLEAR;
         default:  pc = PC_CLEAR;
      endcase
      return pc;
   endfunction

   // Emitting steps fall back to idle through an unconditional jump.
   function automatic ctrl_word_type ucode(input logic [PC_W-1:0] pc);
      ctrl_word_type w;
      case (pc)
         PC_ALLOC:   w = mk(COND_BLK_OOR, PC_A_RANGE, PTR_ONE, CNT_HOLD, WR_NONE, 1'b0,
                            RES_ZERO, ST_OK);
         PC_A_TEST:  w = mk(COND_RD_ZERO, PC_A_HIT, PTR_HOLD, CNT_HOLD, WR_NONE, 1'b0,
                            RES_ZERO, ST_OK);
         PC_A_STEP:  w = mk(COND_NOT_LAST, PC_A_TEST, PTR_INC, CNT_HOLD, WR_NONE, 1'b0,
                            RES_ZERO, ST_OK);
         PC_A_FULL:  w = mk(COND_ALWAYS, PC_IDLE, PTR_HOLD, CNT_HOLD, WR_NONE, 1'b1,
                            RES_ZERO, ST_FULL);
         PC_A_HIT:   w = mk(COND_BLK_ZERO, PC_A_OK, PTR_HOLD, CNT_HOLD, WR_PTR_END, 1'b0,
                            RES_ZERO, ST_OK);
         PC_A_LINK:  w = mk(COND_NEXT, PC_IDLE, PTR_HOLD, CNT_HOLD, WR_BLK_LINK, 1'b0,
                            RES_ZERO, ST_OK);
         PC_A_OK:    w = mk(COND_ALWAYS, PC_IDLE, PTR_HOLD, CNT_HOLD, WR_NONE, 1'b1,
                            RES_PTR, ST_OK);
         PC_A_RANGE: w = mk(COND_ALWAYS, PC_IDLE, PTR_HOLD, CNT_HOLD, WR_NONE, 1'b1,
                            RES_ZERO, ST_RANGE);
         PC_FREE:    w = mk(COND_PTR_END, PC_F_OK, PTR_HOLD, CNT_HOLD, WR_NONE, 1'b0,
                            RES_ZERO, ST_OK);
         PC_F_OOR:   w = mk(COND_PTR_OOR, PC_F_RANGE, PTR_HOLD, CNT_HOLD, WR_NONE, 1'b0,
                            RES_ZERO, ST_OK);
         PC_F_CNT:   w = mk(COND_CNT_FULL, PC_F_LONG, PTR_HOLD, CNT_HOLD, WR_NONE, 1'b0,
                            RES_ZERO, ST_OK);
         PC_F_STEP:  w = mk(COND_ALWAYS, PC_FREE, PTR_LOAD_RD, CNT_INC, WR_PTR_FREE, 1'b0,
                            RES_ZERO, ST_OK);
         PC_F_OK:    w = mk(COND_ALWAYS, PC_IDLE, PTR_HOLD, CNT_HOLD, WR_NONE, 1'b1,
                            RES_ZERO, ST_OK);
         PC_F_RANGE: w = mk(COND_ALWAYS, PC_IDLE, PTR_HOLD, CNT_HOLD, WR_NONE, 1'b1,
                            RES_ZERO, ST_RANGE);
         PC_F_LONG:  w = mk(COND_ALWAYS, PC_IDLE, PTR_HOLD, CNT_HOLD, WR_NONE, 1'b1,
                            RES_ZERO, ST_LOOP);
         PC_READ:    w = mk(COND_PTR_OOR, PC_R_RANGE, PTR_HOLD, CNT_HOLD, WR_NONE, 1'b0,
                            RES_ZERO, ST_OK);
         PC_R_OK:    w = mk(COND_ALWAYS, PC_IDLE, PTR_HOLD, CNT_HOLD, WR_NONE, 1'b1,
                            RES_RD, ST_OK);
         PC_R_RANGE: w = mk(COND_ALWAYS, PC_IDLE, PTR_HOLD, CNT_HOLD, WR_NONE, 1'b1,
                            RES_ZERO, ST_RANGE);
         PC_CLEAR:   w = mk(COND_NEXT, PC_IDLE, PTR_ZERO, CNT_HOLD, WR_NONE, 1'b0,
                            RES_ZERO, ST_OK);
         PC_C_LOOP:  w = mk(COND_NOT_LAST, PC_C_LOOP, PTR_INC, CNT_HOLD, WR_PTR_FREE, 1'b0,
                            RES_ZERO, ST_OK);
         PC_C_DONE:  w = mk(COND_ALWAYS, PC_IDLE, PTR_HOLD, CNT_HOLD, WR_NONE, 1'b1,
                            RES_ZERO, ST_OK);
         default:    w = mk(COND_NEXT, PC_IDLE, PTR_HOLD, CNT_HOLD, WR_NONE, 1'b0,
                            RES_ZERO, ST_OK);
      endcase
      return w;
   endfunction

endpackage

>>> rtl/fat_chain_allocator_unit.sv
// Top level of the FAT chain allocator: table memory, datapath and sequencer.
//
// Requests enter on req_data (operation, block) and are taken at a clock edge
// where start is high and busy is low. One result follows each request on
// rsp_data, shown for a single cycle with rsp_valid high; the receiver has no
// way to hold it, so it must take it in that cycle. busy falls in the cycle
// the result is shown, so the next request may be issued then.
// A microcoded sequencer drives one table memory with a registered read port:
//   read          returns the entry of the given block
//   allocate      marks the first free entry from block 1 as a chain end and
//                 links a previous block to it when one is given; an
//                 out-of-range block is refused
//   free chain    frees each entry of the chain in turn
//   clear table   marks every entry free, one entry after another
// After reset the same clearing pass runs silently, with busy high and no
// result shown; the table then reads as all free.
// Only one request is in progress at a time.
module fat_chain_allocator_unit (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  fca_pkg::req_type req_data,
   output logic             busy,
   output logic             rsp_valid,
   output fca_pkg::rsp_type rsp_data
);
   import fca_pkg::*;

   logic [15:0] fat_mem [NUM_BLOCKS];

   ctrl_word_type ctrl;
   flags_type     flags;
   logic          accept;

   logic [15:0] ptr_ff, ptr_in;
   logic [15:0] cnt_ff, cnt_in;
   logic [15:0] blk_ff;
   logic [15:0] rd_ff;
   logic        silent_ff;
   logic        rsp_valid_ff;
   rsp_type     rsp_ff;

   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr;
   logic [15:0]       wr_data;
   logic [15:0]       res_value;

   assign accept = start && !busy;

   fca_sequencer u_seq (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .operation (req_data.operation),
      .flags     (flags),
      .ctrl      (ctrl),
      .busy      (busy)
   );

   always_comb begin
      flags.blk_oor  = (blk_ff != FREE_MARK) && (blk_ff >= BLK_LIMIT);
      flags.blk_zero = (blk_ff == FREE_MARK);
      flags.rd_zero  = (rd_ff == FREE_MARK);
      flags.ptr_last = (ptr_ff == BLK_LAST);
      flags.ptr_end  = (ptr_ff == FREE_MARK) || (ptr_ff == END_MARK);
      flags.ptr_oor  = (ptr_ff >= BLK_LIMIT);
      flags.cnt_full = (cnt_ff >= BLK_LIMIT);
   end

   always_comb begin
      if (accept) begin
         ptr_in = req_data.block;
      end else begin
         case (ctrl.ptr_op)
            PTR_HOLD:    ptr_in = ptr_ff;
            PTR_ONE:     ptr_in = 16'd1;
            PTR_ZERO:    ptr_in = 16'd0;
            PTR_INC:     ptr_in = ptr_ff + 16'd1;
            PTR_LOAD_RD: ptr_in = rd_ff;
            default:     ptr_in = ptr_ff;
         endcase
      end
   end

   always_comb begin
      if (accept) begin
         cnt_in = 16'd0;
      end else if (ctrl.cnt_op == CNT_INC) begin
         cnt_in = cnt_ff + 16'd1;
      end else begin
         cnt_in = cnt_ff;
      end
   end

   always_comb begin
      case (ctrl.wr_op)
         WR_PTR_FREE: begin
            wr_en   = 1'b1;
            wr_addr = ptr_ff[ADDR_W-1:0];
            wr_data = FREE_MARK;
         end
         WR_PTR_END: begin
            wr_en   = 1'b1;
            wr_addr = ptr_ff[ADDR_W-1:0];
            wr_data = END_MARK;
         end
         WR_BLK_LINK: begin
            wr_en   = 1'b1;
            wr_addr = blk_ff[ADDR_W-1:0];
            wr_data = ptr_ff;
         end
         default: begin
            wr_en   = 1'b0;
            wr_addr = ptr_ff[ADDR_W-1:0];
            wr_data = FREE_MARK;
         end
      endcase
   end

   always_comb begin
      case (ctrl.res_sel)
         RES_PTR: res_value = ptr_ff;
         RES_RD:  res_value = rd_ff;
         default: res_value = 16'd0;
      endcase
   end

   // read is addressed by the next pointer value, so rd_ff holds the entry at ptr_ff
   always_ff @(posedge clock) begin
      if (wr_en) begin
         fat_mem[wr_addr] <= wr_data;
      end
      rd_ff <= fat_mem[ptr_in[ADDR_W-1:0]];
   end

   always_ff @(posedge clock) begin
      ptr_ff <= ptr_in;
      cnt_ff <= cnt_in;
      if (accept) begin
         blk_ff <= req_data.block;
      end
      if (ctrl.emit) begin
         rsp_ff.result_block <= res_value;
         rsp_ff.freed_count  <= cnt_ff;
         rsp_ff.status       <= ctrl.status;
      end
   end

   // drop the result of the clearing pass that follows reset
   always_ff @(posedge clock) begin
      if (reset) begin
         silent_ff    <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= ctrl.emit && !silent_ff;
         if (ctrl.emit) begin
            silent_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

>>> rtl/fca_sequencer.sv
// Step counter and microcode lookup of the FAT chain allocator.
module fca_sequencer (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   accept,
   input  logic [1:0]             operation,
   input  fca_pkg::flags_type     flags,
   output fca_pkg::ctrl_word_type ctrl,
   output logic                   busy
);
   import fca_pkg::*;

   logic [PC_W-1:0] upc_ff;
   logic [PC_W-1:0] upc_in;
   logic            take;

   assign ctrl = ucode(upc_ff);
   assign busy = (upc_ff != PC_IDLE);

   always_comb begin
      case (ctrl.cond)
         COND_NEXT:     take = 1'b0;
         COND_ALWAYS:   take = 1'b1;
         COND_BLK_OOR:  take = flags.blk_oor;
         COND_RD_ZERO:  take = flags.rd_zero;
         COND_NOT_LAST: take = !flags.ptr_last;
         COND_PTR_END:  take = flags.ptr_end;
         COND_PTR_OOR:  take = flags.ptr_oor;
         COND_CNT_FULL: take = flags.cnt_full;
         COND_BLK_ZERO: take = flags.blk_zero;
         default:       take = 1'b0;
      endcase
   end

   always_comb begin
      if (upc_ff == PC_IDLE) begin
         upc_in = accept ? entry_pc(operation) : PC_IDLE;
      end else if (take) begin
         upc_in = ctrl.target;
      end else begin
         upc_in = upc_ff + PC_W'(1);
      end
   end

   // reset starts the clearing pass
   always_ff @(posedge clock) begin
      if (reset) begin
         upc_ff <= PC_CLEAR;
      end else begin
         upc_ff <= upc_in;
      end
   end

endmodule

>>> rtl/fca_checker.sv
// Port-level assertions for the FAT chain allocator, bound to the top level.
module fca_checker (
   input logic             clock,
   input logic             reset,
   input logic             start,
   input logic             busy,
   input logic             rsp_valid,
   input fca_pkg::rsp_type rsp_data
);
   import fca_pkg::*;

   a_busy_after_reset: assert property (@(posedge clock)
      reset |=> busy)
      else $error("busy low straight after reset");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted request did not raise busy");

   a_result_ends_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (!busy && $past(busy)))
      else $error("result shown outside the end of a busy period");

   a_full_has_no_block: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_data.status == ST_FULL)) |->
         ((rsp_data.result_block == 16'd0) && (rsp_data.freed_count == 16'd0)))
      else $error("disk full result carries a block or a count");

   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe held for more than one cycle");

endmodule

bind fat_chain_allocator_unit fca_checker u_fca_checker (.*);
